### rtl/scc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types, codes and the seven-segment table of the settable clock.
// ----------------------------------------------------------------------------
package scc_pkg;

   // transaction opcodes, code 3 is unused and does nothing
   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_SCAN    = 2'd1,
      OP_REFRESH = 2'd2
   } op_type;

   // set mode, code 3 is never reached and behaves as off for refresh
   typedef enum logic [1:0] {
      SET_OFF   = 2'd0,
      SET_RIGHT = 2'd1,
      SET_LEFT  = 2'd2
   } setmode_type;

   // keypad codes
   localparam logic [2:0] KEY_NONE = 3'd0;
   localparam logic [2:0] KEY_VIEW = 3'd1;
   localparam logic [2:0] KEY_MODE = 3'd2;
   localparam logic [2:0] KEY_INC  = 3'd3;
   localparam logic [2:0] KEY_LAST = 3'd4;

   // reset time of day
   localparam logic [4:0] HOUR_RESET = 5'd12;

   // display result
   typedef struct packed {
      logic [7:0] column_strobe;
      logic [7:0] segment_pattern;
   } rsp_type;

   // active-low segment pattern of one decimal digit
   function automatic logic [7:0] seg_code(input logic [3:0] digit);
      logic [7:0] code;
      unique case (digit)
         4'd0:    code = 8'b1100_0000;
         4'd1:    code = 8'b1111_1001;
         4'd2:    code = 8'b1010_0100;
         4'd3:    code = 8'b1011_0000;
         4'd4:    code = 8'b1001_1001;
         4'd5:    code = 8'b1001_0010;
         4'd6:    code = 8'b1000_0010;
         4'd7:    code = 8'b1111_1000;
         4'd8:    code = 8'b1000_0000;
         4'd9:    code = 8'b1001_0000;
         default: code = 8'b1111_1111;
      endcase
      return code;
   endfunction

endpackage

### rtl/scc_channel_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc channel interfaces
// Valid/ready channels for request transactions and display responses.
// ----------------------------------------------------------------------------
interface scc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] row_pins;
   logic [7:0] col_pins;

   modport source (output valid, output opcode, output row_pins, output col_pins,
                   input ready);
   modport sink   (input valid, input opcode, input row_pins, input col_pins,
                   output ready);
endinterface

interface scc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] column_strobe;
   logic [7:0] segment_pattern;

   modport source (output valid, output column_strobe, output segment_pattern,
                   input ready);
   modport sink   (input valid, input column_strobe, input segment_pattern,
                   output ready);
endinterface

### rtl/scc_key_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_key_decode
// Turns the row and column pin reads into a key number 0..4.
// ----------------------------------------------------------------------------
module scc_key_decode (
   input  logic [7:0] row_pins,
   input  logic [7:0] col_pins,
   output logic [2:0] key
);
   import scc_pkg::*;

   // position 1..8 of a single set bit, 0 when not exactly one bit is set
   function automatic logic [3:0] onehot_pos(input logic [7:0] v);
      logic [3:0] p;
      unique case (v)
         8'h01:   p = 4'd1;
         8'h02:   p = 4'd2;
         8'h04:   p = 4'd3;
         8'h08:   p = 4'd4;
         8'h10:   p = 4'd5;
         8'h20:   p = 4'd6;
         8'h40:   p = 4'd7;
         8'h80:   p = 4'd8;
         default: p = 4'd0;
      endcase
      return p;
   endfunction

   logic [3:0]        row_pos;
   logic [3:0]        col_pos;
   logic signed [6:0] key_raw;

   assign row_pos = onehot_pos(row_pins ^ 8'hF0);
   assign col_pos = onehot_pos(col_pins ^ 8'h0F);

   // key = (row - 1) * 4 + column with row = position - 4
   assign key_raw = ((signed'({3'b000, row_pos}) - 7'sd5) <<< 2)
                    + signed'({3'b000, col_pos});

   // anything outside the keypad reads as no key
   always_comb begin
      if (key_raw < 7'sd0 || key_raw > signed'({4'b0000, KEY_LAST})) begin
         key = KEY_NONE;
      end else begin
         key = key_raw[2:0];
      end
   end

endmodule

### rtl/scc_time_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_time_core
// Time of day, set mode and display scan state, updated once per transaction.
// ----------------------------------------------------------------------------
module scc_time_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [1:0]       opcode,
   input  logic [2:0]       key,
   output scc_pkg::rsp_type result
);
   import scc_pkg::*;

   logic [5:0]  second_ff, second_in;
   logic [5:0]  minute_ff, minute_in;
   logic [4:0]  hour_ff, hour_in;
   logic        show_seconds_ff, show_seconds_in;
   setmode_type set_mode_ff, set_mode_in;
   logic        click_armed_ff, click_armed_in;
   logic [2:0]  current_key_ff, current_key_in;
   logic [1:0]  digit_index_ff, digit_index_in;

   logic [6:0]  sec_t;
   logic [6:0]  min_t;
   logic [5:0]  hour_t;
   logic [5:0]  right_val;
   logic [5:0]  left_val;
   logic [5:0]  pair_val;
   logic [2:0]  tens;
   logic [5:0]  ones;
   logic [3:0]  digit;
   logic [2:0]  next_idx;

   // tens digit of a value below 64
   function automatic logic [2:0] tens_of(input logic [5:0] v);
      logic [2:0] t;
      priority if (v >= 6'd60) t = 3'd6;
      else if (v >= 6'd50)     t = 3'd5;
      else if (v >= 6'd40)     t = 3'd4;
      else if (v >= 6'd30)     t = 3'd3;
      else if (v >= 6'd20)     t = 3'd2;
      else if (v >= 6'd10)     t = 3'd1;
      else                     t = 3'd0;
      return t;
   endfunction

   // display digit selection and segment lookup
   always_comb begin
      right_val = show_seconds_ff ? second_ff : minute_ff;
      left_val  = show_seconds_ff ? minute_ff : {1'b0, hour_ff};
      pair_val  = digit_index_ff[1] ? left_val : right_val;
      tens      = tens_of(pair_val);
      ones      = pair_val - ({3'b000, tens} * 6'd10);
      digit     = digit_index_ff[0] ? {1'b0, tens} : ones[3:0];
      result.column_strobe   = ~(8'd1 << digit_index_ff);
      result.segment_pattern = seg_code(digit);
   end

   // next state per transaction
   always_comb begin
      second_in       = second_ff;
      minute_in       = minute_ff;
      hour_in         = hour_ff;
      show_seconds_in = show_seconds_ff;
      set_mode_in     = set_mode_ff;
      click_armed_in  = click_armed_ff;
      current_key_in  = current_key_ff;
      digit_index_in  = digit_index_ff;
      sec_t           = {1'b0, second_ff};
      min_t           = {1'b0, minute_ff};
      hour_t          = {1'b0, hour_ff};
      next_idx        = {1'b0, digit_index_ff} + 3'd1;

      if (step) begin
         unique case (opcode)
            OP_TICK: begin
               // run the clock only while not setting
               if (set_mode_ff == SET_OFF) begin
                  sec_t = {1'b0, second_ff} + 7'd1;
                  if (sec_t > 7'd59) begin
                     sec_t = '0;
                     min_t = {1'b0, minute_ff} + 7'd1;
                  end
                  if (min_t > 7'd59) begin
                     min_t  = '0;
                     hour_t = {1'b0, hour_ff} + 6'd1;
                  end
                  if (hour_t > 6'd23) begin
                     hour_t = '0;
                  end
                  second_in = sec_t[5:0];
                  minute_in = min_t[5:0];
                  hour_in   = hour_t[4:0];
               end
            end
            OP_SCAN: begin
               current_key_in = key;
               // mode key advances set mode once per press
               if (key == KEY_MODE && click_armed_ff) begin
                  click_armed_in = 1'b0;
                  unique case (set_mode_ff)
                     SET_OFF:   set_mode_in = SET_RIGHT;
                     SET_RIGHT: set_mode_in = SET_LEFT;
                     default:   set_mode_in = (set_mode_ff == SET_LEFT) ? SET_OFF
                                                                        : SET_RIGHT;
                  endcase
               end
               // release re-arms the click guard
               if (key == KEY_NONE) begin
                  click_armed_in = 1'b1;
               end
               // increment key bumps the pair being set, no carry
               if (key == KEY_INC && click_armed_ff &&
                   (set_mode_ff == SET_RIGHT || set_mode_ff == SET_LEFT)) begin
                  click_armed_in = 1'b0;
                  sec_t  = {1'b0, second_ff} + 7'd1;
                  min_t  = {1'b0, minute_ff} + 7'd1;
                  hour_t = {1'b0, hour_ff} + 6'd1;
                  if (show_seconds_ff && set_mode_ff == SET_RIGHT) begin
                     second_in = (sec_t >= 7'd60) ? 6'd0 : sec_t[5:0];
                  end else if (show_seconds_ff || set_mode_ff == SET_RIGHT) begin
                     minute_in = (min_t >= 7'd60) ? 6'd0 : min_t[5:0];
                  end else begin
                     hour_in = (hour_t >= 6'd24) ? 5'd0 : hour_t[4:0];
                  end
               end
               // view key toggles the shown pair on every scan
               if (key == KEY_VIEW) begin
                  show_seconds_in = ~show_seconds_ff;
               end
            end
            OP_REFRESH: begin
               // step the digit scan, limited to the pair being set
               unique case (set_mode_ff)
                  SET_LEFT:  digit_index_in = {1'b1, next_idx[0]};
                  SET_RIGHT: digit_index_in = {1'b0, next_idx[0]};
                  default:   digit_index_in = next_idx[1:0];
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff       <= '0;
         minute_ff       <= '0;
         hour_ff         <= HOUR_RESET;
         show_seconds_ff <= 1'b1;
         set_mode_ff     <= SET_OFF;
         click_armed_ff  <= 1'b0;
         current_key_ff  <= KEY_NONE;
         digit_index_ff  <= '0;
      end else begin
         second_ff       <= second_in;
         minute_ff       <= minute_in;
         hour_ff         <= hour_in;
         show_seconds_ff <= show_seconds_in;
         set_mode_ff     <= set_mode_in;
         click_armed_ff  <= click_armed_in;
         current_key_ff  <= current_key_in;
         digit_index_ff  <= digit_index_in;
      end
   end

endmodule

### rtl/settable_clock_with_seven_segment_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// settable_clock_with_seven_segment_scan
// 24-hour settable clock with keypad decode and four-digit display scan.
// ----------------------------------------------------------------------------
// Each request transaction is a one-second tick, a keypad scan or a display
// refresh; only a refresh produces a response, carrying the active-low column
// strobe and segment pattern of the next digit. The block takes one
// transaction per cycle while request ready is high: a transaction is held in
// the input register, is applied to the clock state when it leaves it, and a
// refresh response is then presented from the result register. Request ready
// drops only while a refresh waits in the input register behind an untaken
// response.
module settable_clock_with_seven_segment_scan (
   input logic clock,
   input logic reset,
   scc_req_if.sink   req_ch,
   scc_rsp_if.source rsp_ch
);
   import scc_pkg::*;

   logic       in_valid_ff;
   logic [1:0] in_opcode_ff;
   logic [7:0] in_row_ff;
   logic [7:0] in_col_ff;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_data_ff;

   logic       out_free;
   logic       is_refresh;
   logic       step;
   logic [2:0] key;
   rsp_type    result;

   // handshake control
   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign is_refresh   = (in_opcode_ff == OP_REFRESH);
   assign step         = in_valid_ff && (!is_refresh || out_free);
   assign req_ch.ready = !in_valid_ff || step;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_opcode_ff <= req_ch.opcode;
         in_row_ff    <= req_ch.row_pins;
         in_col_ff    <= req_ch.col_pins;
      end
   end

   scc_key_decode u_key_decode (
      .row_pins (in_row_ff),
      .col_pins (in_col_ff),
      .key      (key)
   );

   scc_time_core u_time_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .opcode (in_opcode_ff),
      .key    (key),
      .result (result)
   );

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (step && is_refresh) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && is_refresh) begin
         out_data_ff <= result;
      end
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.column_strobe   = out_data_ff.column_strobe;
   assign rsp_ch.segment_pattern = out_data_ff.segment_pattern;

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the settable clock with seven-segment scan.
// ----------------------------------------------------------------------------
// Feeds ticks, keypad scans and display refreshes through the request
// channel. A predictor of the clock, keypad and digit scan runs on every
// accepted request, and each refresh response is compared with the oldest
// predicted strobe and segment pair. Key presses are mostly well-formed
// press/release sequences that set the time, plus random pin noise. Both
// channel sides idle at random, except in one calm stretch.
// ----------------------------------------------------------------------------
module tb;
   import scc_pkg::*;

   // unused opcode, must be ignored by the block
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int         RANDOM_ITEMS = 2000;
   // idling is switched off while the count of taken requests is at least CALM_FROM and below CALM_TO
   localparam int         CALM_FROM = 900;
   localparam int         CALM_TO   = 1250;
   // active-low glyphs of digits 9 down to 0
   localparam logic [79:0] GLYPHS = {8'h90, 8'h80, 8'hF8, 8'h82, 8'h92,
                                     8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0};

   typedef struct {
      logic [1:0] opcode;
      logic [7:0] rows;
      logic [7:0] cols;
      bit         drain;
   } clock_req_type;

   logic clock;
   logic reset;

   scc_req_if req_ch ();
   scc_rsp_if rsp_ch ();

   settable_clock_with_seven_segment_scan i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   clock_req_type pending[$];
   rsp_type     digit_queue[$];
   bit          drain_next;
   int          planned;
   int          errors;
   int          taken;
   int          n_tick, n_scan, n_refresh, n_checked;
   int          mode_steps, day_wraps, minute_wraps;
   int          gen_mode;

   // predicted clock state
   logic [5:0]  sec_q;
   logic [5:0]  min_q;
   logic [4:0]  hour_q;
   logic        view_sec;
   setmode_type mode_q;
   logic        armed;
   logic [1:0]  digit_q;

   // clock generation
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #5ms;
      $display("TEST FAILED");
      $finish;
   end

   // position 1..8 of a single set bit, zero when not one-hot
   function automatic int pin_pos(logic [7:0] v);
      int p;
      p = 0;
      if (v != 8'h00 && (v & (v - 8'h01)) == 8'h00) begin
         for (int i = 0; i < 8; i++) begin
            if (v[i]) p = i + 1;
         end
      end
      return p;
   endfunction

   function automatic logic [2:0] decode_key(logic [7:0] rows, logic [7:0] cols);
      int r, c, k;
      r = pin_pos(rows ^ 8'hF0) - 4;
      c = pin_pos(cols ^ 8'h0F);
      k = (r - 1) * 4 + c;
      if (k < 0 || k > 4) k = 0;
      return k[2:0];
   endfunction

   function automatic logic [7:0] row_byte(int pos);
      return ((pos == 0) ? 8'h00 : (8'h01 << (pos - 1))) ^ 8'hF0;
   endfunction

   function automatic logic [7:0] col_byte(int pos);
      return ((pos == 0) ? 8'h00 : (8'h01 << (pos - 1))) ^ 8'h0F;
   endfunction

   function automatic bit take_break();
      return !(taken >= CALM_FROM && taken < CALM_TO) && $urandom_range(99) < 31;
   endfunction

   // predictor: update the clock state and queue the digit a refresh shows
   task automatic apply_to_clock(clock_req_type it);
      logic [2:0] key;
      logic [5:0] right, left, val;
      logic [2:0] nxt;
      rsp_type    shown;
      case (it.opcode)
         OP_TICK: begin
            n_tick++;
            if (mode_q == SET_OFF) begin
               sec_q = sec_q + 6'd1;
               if (sec_q > 6'd59) begin
                  sec_q = 6'd0;
                  min_q = min_q + 6'd1;
               end
               if (min_q > 6'd59) begin
                  min_q = 6'd0;
                  hour_q = hour_q + 5'd1;
                  minute_wraps++;
               end
               if (hour_q > 5'd23) begin
                  hour_q = 5'd0;
                  day_wraps++;
               end
            end
         end
         OP_SCAN: begin
            n_scan++;
            key = decode_key(it.rows, it.cols);
            if (key == KEY_MODE && armed) begin
               armed = 1'b0;
               mode_q = setmode_type'((mode_q + 1) % 3);
               mode_steps++;
            end
            if (key == KEY_NONE) armed = 1'b1;
            if (key == KEY_INC && armed && (mode_q == SET_RIGHT || mode_q == SET_LEFT)) begin
               armed = 1'b0;
               if (view_sec && mode_q == SET_RIGHT) begin
                  sec_q = (sec_q == 6'd59) ? 6'd0 : sec_q + 6'd1;
               end else if (view_sec || mode_q == SET_RIGHT) begin
                  min_q = (min_q == 6'd59) ? 6'd0 : min_q + 6'd1;
               end else begin
                  hour_q = (hour_q == 5'd23) ? 5'd0 : hour_q + 5'd1;
               end
            end
            if (key == KEY_VIEW) view_sec = ~view_sec;
         end
         OP_REFRESH: begin
            n_refresh++;
            right = view_sec ? sec_q : min_q;
            left  = view_sec ? min_q : {1'b0, hour_q};
            case (digit_q)
               2'd0:    val = right % 10;
               2'd1:    val = (right / 10) % 10;
               2'd2:    val = left % 10;
               default: val = (left / 10) % 10;
            endcase
            shown.column_strobe   = ~(8'h01 << digit_q);
            shown.segment_pattern = GLYPHS[val * 8 +: 8];
            digit_queue.push_back(shown);
            nxt = {1'b0, digit_q} + 3'd1;
            if (mode_q == SET_LEFT)       digit_q = 2'd2 + nxt[0];
            else if (mode_q == SET_RIGHT) digit_q = {1'b0, nxt[0]};
            else                          digit_q = nxt[1:0];
         end
         default: ;
      endcase
   endtask

   task automatic add_item(logic [1:0] opc, logic [7:0] r, logic [7:0] c);
      clock_req_type it;
      it.opcode = opc;
      it.rows   = r;
      it.cols   = c;
      it.drain  = drain_next;
      drain_next = 1'b0;
      pending.push_back(it);
      if (opc != OP_UNUSED) planned++;
   endtask

   // scan with one-hot row and column positions, zero meaning no pin
   task automatic press(int rpos, int cpos);
      add_item(OP_SCAN, row_byte(rpos), col_byte(cpos));
   endtask

   task automatic add_plain(logic [1:0] opc);
      add_item(opc, $urandom_range(255), $urandom_range(255));
   endtask

   // request driver
   always @(posedge clock) begin : drive_req
      bit go;
      if (reset) begin
         req_ch.valid    <= 1'b0;
         req_ch.opcode   <= OP_TICK;
         req_ch.row_pins <= 8'h00;
         req_ch.col_pins <= 8'h00;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            apply_to_clock(pending.pop_front());
            taken++;
         end
         // a stalled transaction stays on the bus unchanged
         if (!(req_ch.valid && !req_ch.ready)) begin
            go = pending.size() > 0 && !take_break();
            if (go && pending[0].drain && digit_queue.size() != 0) go = 1'b0;
            req_ch.valid <= go;
            if (go) begin
               req_ch.opcode   <= pending[0].opcode;
               req_ch.row_pins <= pending[0].rows;
               req_ch.col_pins <= pending[0].cols;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin : watch_rsp
      rsp_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (digit_queue.size() == 0) begin
               $display("%0t: unexpected response strobe %h segments %h", $time,
                        rsp_ch.column_strobe, rsp_ch.segment_pattern);
               errors++;
            end else begin
               want = digit_queue.pop_front();
               n_checked++;
               if (rsp_ch.column_strobe !== want.column_strobe) begin
                  $display("%0t: column_strobe expected %h actual %h", $time,
                           want.column_strobe, rsp_ch.column_strobe);
                  errors++;
               end
               if (rsp_ch.segment_pattern !== want.segment_pattern) begin
                  $display("%0t: segment_pattern expected %h actual %h", $time,
                           want.segment_pattern, rsp_ch.segment_pattern);
                  errors++;
               end
            end
         end
         rsp_ch.ready <= !take_break();
      end
   end

   // stimulus and end of run
   initial begin : stimulus
      int pick, n, incs;
      reset = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.opcode   = OP_TICK;
      req_ch.row_pins = 8'h00;
      req_ch.col_pins = 8'h00;
      rsp_ch.ready    = 1'b0;
      sec_q    = 6'd0;
      min_q    = 6'd0;
      hour_q   = HOUR_RESET;
      view_sec = 1'b1;
      mode_q   = SET_OFF;
      armed    = 1'b0;
      digit_q  = 2'd0;
      gen_mode = 0;

      // directed: reset display, view toggle, unused opcode, invalid reads,
      // guard against held keys, setting both pairs, out-of-range key
      repeat (4) add_plain(OP_REFRESH);
      add_plain(OP_TICK);
      add_plain(OP_REFRESH);
      press(5, 1);
      add_plain(OP_REFRESH);
      add_plain(OP_REFRESH);
      add_item(OP_UNUSED, 8'hFF, 8'hFF);
      add_item(OP_SCAN, 8'h00, 8'h00);
      press(5, 2);
      press(5, 2);
      press(5, 3);
      press(0, 0);
      press(5, 3);
      add_plain(OP_REFRESH);
      add_plain(OP_TICK);
      press(0, 0);
      press(5, 2);
      press(0, 0);
      press(5, 3);
      add_plain(OP_REFRESH);
      press(6, 0);
      add_item(OP_SCAN, 8'hFF, 8'hFF);
      gen_mode = 2;

      // random part, mostly well-formed key sequences
      drain_next = 1'b1;
      planned = 0;
      while (planned < RANDOM_ITEMS) begin
         if ($urandom_range(99) < 3) drain_next = 1'b1;
         pick = $urandom_range(99);
         if (pick < 35) begin
            // let the clock run with the display scanning
            n = $urandom_range(1, 90);
            repeat (n) begin
               add_plain(OP_TICK);
               if ($urandom_range(3) == 0) add_plain(OP_REFRESH);
            end
         end else if (pick < 65) begin
            // set session: step the mode, bump the selected pair
            n = $urandom_range(1, 3);
            repeat (n) begin
               press(5, 2);
               if ($urandom_range(3) == 0) press(5, 2);
               press(0, 0);
               gen_mode = (gen_mode + 1) % 3;
            end
            incs = ($urandom_range(9) == 0) ? $urandom_range(40, 70) : $urandom_range(0, 12);
            repeat (incs) begin
               press(5, 3);
               if ($urandom_range(4) == 0) press(5, 3);
               press(0, 0);
               if ($urandom_range(2) == 0) add_plain(OP_REFRESH);
               if ($urandom_range(9) == 0) add_plain(OP_TICK);
               if ($urandom_range(14) == 0) begin
                  press(5, 1);
                  press(0, 0);
               end
            end
            // usually leave setting so that the clock runs again
            if ($urandom_range(9) < 6) begin
               while (gen_mode != 0) begin
                  press(5, 2);
                  press(0, 0);
                  gen_mode = (gen_mode + 1) % 3;
               end
            end
         end else if (pick < 75) begin
            // view key held over a few scans
            repeat ($urandom_range(1, 3)) press(5, 1);
            press(0, 0);
            repeat ($urandom_range(0, 4)) add_plain(OP_REFRESH);
         end else if (pick < 85) begin
            repeat ($urandom_range(1, 8)) add_plain(OP_REFRESH);
         end else begin
            // pin noise and any opcode
            repeat ($urandom_range(1, 6)) add_plain($urandom_range(3));
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending.size() != 0 || digit_queue.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (digit_queue.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, digit_queue.size());
         errors++;
      end

      $display("run: %0d ticks, %0d scans, %0d refreshes, %0d responses checked",
               n_tick, n_scan, n_refresh, n_checked);
      $display("run: %0d set mode steps, %0d hour carries, %0d day rollovers",
               mode_steps, minute_wraps, day_wraps);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
